/* design/srt_pkg.sv */
// Package: shared constants and types for the sorted rank table.
package srt_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int RANK_W   = 6;
	localparam int POS_W    = $clog2(CAPACITY + 1);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic cmp;
		logic upd;
	} srt_ctl_t;

endpackage

/* design/srt_cell.sv */
// One table slot: holds a key, compares it with the request key, shifts on insert.
module srt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  srt_pkg::srt_ctl_t ctl,
	input  srt_pkg::key_t    key,
	input  srt_pkg::key_t    left_key,
	input  logic             left_valid,
	input  logic             left_gt,
	output srt_pkg::key_t    cell_key,
	output logic             cell_valid,
	output logic             cell_gt,
	output logic             cell_eq
);
	import srt_pkg::*;

	key_t key_q;
	logic valid_q;
	logic gt_q;
	logic eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.upd && !gt_q) begin
			valid_q <= left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && !gt_q) begin
			key_q <= left_gt ? key : left_key;
		end
		if (ctl.cmp) begin
			gt_q <= valid_q && (key_q > key);
			eq_q <= valid_q && (key_q == key);
		end
	end

	assign cell_key   = key_q;
	assign cell_valid = valid_q;
	assign cell_gt    = gt_q;
	assign cell_eq    = eq_q;

endmodule

/* design/srt_encode.sv */
// Position encoder: turns the row of greater-than flags into an insert position.
module srt_encode (
	input  logic [srt_pkg::CAPACITY-1:0] gt,
	output logic [srt_pkg::POS_W-1:0]    pos
);
	import srt_pkg::*;

	logic [CAPACITY:0] boundary;

	always_comb begin
		boundary[0] = !gt[0];
		for (int i = 1; i < CAPACITY; i++) begin
			boundary[i] = gt[i-1] && !gt[i];
		end
		boundary[CAPACITY] = gt[CAPACITY-1];
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i <= CAPACITY; i++) begin
			if (boundary[i]) begin
				pos = pos | POS_W'(i);
			end
		end
	end

endmodule

/* design/sorted_rank_table.sv */
// Top level: descending key table with insert and rank query over a row of cells.
//
// Request channel: req_valid/req_stall carry req_type (0 insert, 1 query) and a
// signed 32-bit key. Response channel: rsp_valid/rsp_stall carry rank, found
// and dropped, one response per request, in request order.
// A request is taken when the block is idle or in the cycle its predecessor
// writes its response. The key is broadcast to all cells; each cell compares
// in the compare step, and in the update step an insert shifts the row once
// toward the tail while the position encoder forms the rank. A request thus
// passes the compare-then-shift of the cell row, and the response register is
// loaded at the end of the update step.
// When the response register is full and rsp_stall is high, the block holds
// in its update step and stalls the request side until the transfer happens.
// A full table drops its tail entry on insert, or the new key if it ranks
// below every entry, and flags it on dropped.
// Reset (arst_n low) empties the table, clears the response valid and returns the block to idle.
module sorted_rank_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        req_type,
	input  srt_pkg::key_t               key,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [srt_pkg::RANK_W-1:0]  rank,
	output logic                        found,
	output logic                        dropped
);
	import srt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} srt_state_t;

	srt_state_t state_q;
	srt_state_t state_d;

	logic req_type_s1;
	key_t key_s1;

	logic              rsp_valid_q;
	logic [RANK_W-1:0] rank_q;
	logic              found_q;
	logic              dropped_q;

	logic out_free;
	logic upd_go;
	logic take;

	srt_ctl_t ctl;

	key_t              row_key   [CAPACITY];
	logic [CAPACITY-1:0] row_valid;
	logic [CAPACITY-1:0] row_gt;
	logic [CAPACITY-1:0] row_eq;
	logic [POS_W-1:0]  pos;

	logic              res_found;
	logic              res_dropped;
	logic [RANK_W-1:0] res_rank;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign upd_go    = (state_q == ST_UPD) && out_free;
	assign req_stall = !((state_q == ST_IDLE) || upd_go);
	assign take      = req_valid && !req_stall;

	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = take ? ST_CMP : ST_IDLE;
			ST_CMP:  state_d = ST_UPD;
			ST_UPD:  state_d = upd_go ? (take ? ST_CMP : ST_IDLE) : ST_UPD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_type_s1 <= req_type;
			key_s1      <= key;
		end
	end

	assign ctl.cmp = (state_q == ST_CMP);
	assign ctl.upd = upd_go && (req_type_s1 == REQ_INSERT);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			srt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.key        (key_s1),
				.left_key   (key_s1),
				.left_valid (1'b1),
				.left_gt    (1'b0),
				.cell_key   (row_key[i]),
				.cell_valid (row_valid[i]),
				.cell_gt    (row_gt[i]),
				.cell_eq    (row_eq[i])
			);
		end else begin : g_body
			srt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.key        (key_s1),
				.left_key   (row_key[i-1]),
				.left_valid (row_valid[i-1]),
				.left_gt    (row_gt[i-1]),
				.cell_key   (row_key[i]),
				.cell_valid (row_valid[i]),
				.cell_gt    (row_gt[i]),
				.cell_eq    (row_eq[i])
			);
		end
	end

	srt_encode u_encode (
		.gt  (row_gt),
		.pos (pos)
	);

	always_comb begin
		if (req_type_s1 == REQ_INSERT) begin
			res_dropped = row_valid[CAPACITY-1];
			res_found   = !(row_valid[CAPACITY-1] && row_gt[CAPACITY-1]);
		end else begin
			res_dropped = 1'b0;
			res_found   = |row_eq;
		end
		res_rank = res_found ? RANK_W'(pos) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			rank_q    <= res_rank;
			found_q   <= res_found;
			dropped_q <= res_dropped;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rank      = rank_q;
	assign found     = found_q;
	assign dropped   = dropped_q;

endmodule

/* design/srt_checker.sv */
// Checker: port-level properties of the sorted rank table, bound to the top level.
module srt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        req_type,
	input srt_pkg::key_t               key,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic [srt_pkg::RANK_W-1:0]  rank,
	input logic                        found,
	input logic                        dropped
);
	import srt_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rank) && $stable(found)
			&& $stable(dropped))
		else $error("response changed while stalled");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req_type) && $stable(key))
		else $error("request changed while stalled");

	a_miss_rank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> rank == '0)
		else $error("rank nonzero on miss");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous still comparing");

	a_rsp_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid |=> ##2 rsp_valid)
		else $error("response missing two cycles after transfer");

endmodule

bind sorted_rank_table srt_checker u_srt_checker (.*);

/* bench/tb_sorted_rank_table.sv */
// Testbench for sorted_rank_table: directed and random inserts and rank queries, self-checked.
`timescale 1ns / 1ps

module tb_sorted_rank_table;
	import srt_pkg::*;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              found;
		logic              dropped;
	} rank_result_t;

	typedef struct packed {
		logic         typ;
		key_t         k;
		logic         typed;
		rank_result_t want;
	} stim_row_t;

	localparam key_t         KEY_MAX     = 32'sh7FFFFFFF;
	localparam key_t         KEY_MIN     = 32'sh80000000;
	localparam rank_result_t RANK_MISS   = '{rank: '0, found: 1'b0, dropped: 1'b0};
	localparam rank_result_t RANK_TOP    = '{rank: 6'd0, found: 1'b1, dropped: 1'b0};
	localparam int           N_DIRECTED  = 18;
	localparam int           PHASE_ITEMS = 335;
	localparam int           QUIET_LIMIT = 4000;
	localparam int           DRAIN_WAIT  = 8;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic                req_type  = REQ_INSERT;
	key_t                key       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [RANK_W-1:0]   rank;
	logic                found;
	logic                dropped;

	key_t         table_keys [CAPACITY];
	int           table_count = 0;
	rank_result_t awaited_ranks [$];
	rank_result_t head_rank;
	int           mismatches   = 0;
	int           sender_idle_pct = 0;
	int           stall_pct    = 0;
	int           quiet_cycles = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{REQ_QUERY,  32'sd0,           1'b1, RANK_MISS},
		'{REQ_INSERT, KEY_MAX,          1'b1, RANK_TOP},
		'{REQ_INSERT, KEY_MIN,          1'b1, '{6'd1, 1'b1, 1'b0}},
		'{REQ_INSERT, KEY_MAX,          1'b1, RANK_TOP},
		'{REQ_QUERY,  KEY_MIN,          1'b1, '{6'd2, 1'b1, 1'b0}},
		'{REQ_QUERY,  KEY_MAX,          1'b1, RANK_TOP},
		'{REQ_INSERT, 32'sd0,           1'b0, RANK_MISS},
		'{REQ_INSERT, -32'sd1,          1'b0, RANK_MISS},
		'{REQ_INSERT, 32'sd330,         1'b0, RANK_MISS},
		'{REQ_QUERY,  32'sd330,         1'b0, RANK_MISS},
		'{REQ_INSERT, 32'sd330,         1'b0, RANK_MISS},
		'{REQ_QUERY,  -32'sd1,          1'b0, RANK_MISS},
		'{REQ_QUERY,  32'sd1,           1'b1, RANK_MISS},
		'{REQ_INSERT, 32'sh55555555,    1'b0, RANK_MISS},
		'{REQ_INSERT, 32'shAAAAAAAA,    1'b0, RANK_MISS},
		'{REQ_QUERY,  32'shAAAAAAAA,    1'b0, RANK_MISS},
		'{REQ_INSERT, KEY_MIN,          1'b0, RANK_MISS},
		'{REQ_QUERY,  32'sh12345678,    1'b1, RANK_MISS}
	};

	sorted_rank_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.key       (key),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rank      (rank),
		.found     (found),
		.dropped   (dropped)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic rank_result_t rank_request(input logic typ, input key_t k);
		rank_result_t r;
		int pos;
		int i;
		r = RANK_MISS;
		if (typ == REQ_INSERT) begin
			pos = 0;
			while (pos < table_count && table_keys[pos] > k)
				pos++;
			if (table_count >= CAPACITY)
				r.dropped = 1'b1;
			if (pos < CAPACITY) begin
				for (i = CAPACITY - 1; i > pos; i--)
					table_keys[i] = table_keys[i-1];
				table_keys[pos] = k;
				if (table_count < CAPACITY)
					table_count++;
				r.rank  = pos[RANK_W-1:0];
				r.found = 1'b1;
			end
		end else begin
			for (i = 0; i < table_count; i++) begin
				if (!r.found && table_keys[i] == k) begin
					r.rank  = i[RANK_W-1:0];
					r.found = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic key_t pick_key();
		int   sel;
		key_t k;
		key_t tail;
		sel = $urandom_range(99);
		if (sel < 30) begin
			k = key_t'($urandom);
		end else if (sel < 50) begin
			k = key_t'(int'($urandom_range(40)) - 20);
		end else if (sel < 60) begin
			k = key_t'($urandom_range(99) * 60 + $urandom_range(59));
		end else if (sel < 70) begin
			case ($urandom_range(3))
				0: k = KEY_MAX;
				1: k = KEY_MIN;
				2: k = '0;
				default: k = -32'sd1;
			endcase
		end else if (table_count == 0) begin
			k = key_t'($urandom);
		end else if (sel < 85) begin
			k = table_keys[$urandom_range(table_count - 1)] + key_t'(int'($urandom_range(2)) - 1);
		end else begin
			tail = table_keys[table_count - 1];
			if (tail > KEY_MIN + 32'sd3)
				k = tail - key_t'($urandom_range(3));
			else
				k = tail;
		end
		return k;
	endfunction

	task automatic send_request(input logic typ, input key_t k, input logic typed,
			input rank_result_t typed_want);
		rank_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= typ;
		key       <= k;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = rank_request(typ, k);
		awaited_ranks.insert(awaited_ranks.size(), typed ? typed_want : predicted);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (awaited_ranks.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_ranks.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected transfer, expected none, actual rank %0d found %0b dropped %0b",
						$time, rank, found, dropped);
				end else begin
					head_rank = awaited_ranks.pop_front();
					check_field("rank", int'(head_rank.rank), int'(rank));
					check_field("found", int'(head_rank.found), int'(found));
					check_field("dropped", int'(head_rank.dropped), int'(dropped));
				end
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("sorted_rank_table test failed");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIRECTED; n++)
			send_request(directed_rows[n].typ, directed_rows[n].k, directed_rows[n].typed,
				directed_rows[n].want);
		drain_results();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 88; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 88; end
				default: begin sender_idle_pct = 7; stall_pct = 7; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				send_request(($urandom_range(99) < 55) ? REQ_INSERT : REQ_QUERY, pick_key(),
					1'b0, RANK_MISS);
			drain_results();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_rank_table test passed");
		else
			$display("sorted_rank_table test failed");
		$finish;
	end

endmodule

/* sorted_rank_table.f */
design/srt_pkg.sv
design/srt_cell.sv
design/srt_encode.sv
design/sorted_rank_table.sv
design/srt_checker.sv
bench/tb_sorted_rank_table.sv
